// File: rtl/mdist_pkg.sv
// Shared types and constants for the 2-D Minkowski distance block.
// No dependencies; every other file of the block imports this package.
package mdist_pkg;

  // Width of the distance result, unsigned Q17.0.
  localparam int unsigned DIST_W = 17;

  // Width of the order field.
  localparam int unsigned ORDER_W = 3;

  // Order after clamping to the supported range 1..4.
  typedef enum logic [1:0] {
    ORD_P1 = 2'd0,
    ORD_P2 = 2'd1,
    ORD_P3 = 2'd2,
    ORD_P4 = 2'd3
  } order_e;

  // Control that travels alongside each item down the pipeline.
  typedef struct packed {
    logic   valid;
    order_e order;
  } ctl_t;

endpackage

// File: rtl/minkowski_distance_2d.sv
// Minkowski distance of two 2-D points for orders 1 to 4: floor of the p-th root of
// |dx|^p + |dy|^p, in unsigned Q17.0. The block takes one item in every clock cycle,
// busy_o stays low, and each item runs through the whole pipeline: four front-end
// stages form the differences, their powers and the sum, then a chain of
// COORD_BITS + 1 cells settles one root bit each. Results are shown for one cycle
// with done_o and cannot be held off.
module minkowski_distance_2d #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [15:0]                   first_x_i,
  input  logic [15:0]                   first_y_i,
  input  logic [15:0]                   second_x_i,
  input  logic [15:0]                   second_y_i,
  input  logic [mdist_pkg::ORDER_W-1:0] order_i,
  output logic                          done_o,
  output logic [mdist_pkg::DIST_W-1:0]  distance_o
);
  import mdist_pkg::*;

  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned SUM_W  = 4 * COORD_BITS + 4;

  ctl_t              ctl_l  [ROOT_W+1];
  logic [SUM_W-1:0]  sum_l  [ROOT_W+1];
  logic [ROOT_W-1:0] root_l [ROOT_W+1];
  logic [SUM_W-1:0]  sq_l   [ROOT_W+1];
  logic [SUM_W-1:0]  cube_l [ROOT_W+1];
  logic [SUM_W-1:0]  quad_l [ROOT_W+1];

  // Front end: differences, powers and their sum.
  mdist_prep #(
    .COORD_BITS(COORD_BITS),
    .SUM_W     (SUM_W)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .first_x_i (first_x_i),
    .first_y_i (first_y_i),
    .second_x_i(second_x_i),
    .second_y_i(second_y_i),
    .order_i   (order_i),
    .ctl_o     (ctl_l[0]),
    .sum_o     (sum_l[0])
  );

  // The root search starts from zero.
  assign root_l[0] = '0;
  assign sq_l[0]   = '0;
  assign cube_l[0] = '0;
  assign quad_l[0] = '0;

  // Chain of cells, most significant root bit first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    mdist_cell #(
      .ROOT_W(ROOT_W),
      .SUM_W (SUM_W),
      .BIT   (ROOT_W - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_l[k]),
      .sum_i (sum_l[k]),
      .root_i(root_l[k]),
      .sq_i  (sq_l[k]),
      .cube_i(cube_l[k]),
      .quad_i(quad_l[k]),
      .ctl_o (ctl_l[k+1]),
      .sum_o (sum_l[k+1]),
      .root_o(root_l[k+1]),
      .sq_o  (sq_l[k+1]),
      .cube_o(cube_l[k+1]),
      .quad_o(quad_l[k+1])
    );
  end

  assign busy_o     = 1'b0;
  assign done_o     = ctl_l[ROOT_W].valid;
  assign distance_o = DIST_W'(root_l[ROOT_W]);

endmodule

// File: rtl/mdist_prep.sv
// Front end of the distance block: coordinate differences, their powers and the sum.
// Depends on mdist_pkg.
module mdist_prep #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned SUM_W      = 4 * COORD_BITS + 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [15:0]                  first_x_i,
  input  logic [15:0]                  first_y_i,
  input  logic [15:0]                  second_x_i,
  input  logic [15:0]                  second_y_i,
  input  logic [mdist_pkg::ORDER_W-1:0] order_i,
  output mdist_pkg::ctl_t              ctl_o,
  output logic [SUM_W-1:0]             sum_o
);
  import mdist_pkg::*;

  localparam int unsigned C = COORD_BITS;

  order_e       order_dec;
  logic [C:0]   diff_x, diff_y;
  logic [C:0]   neg_x, neg_y;
  logic [C-1:0] mag_x, mag_y;

  ctl_t           ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [C-1:0]   dx1_q, dy1_q, dx2_q, dy2_q;
  logic [2*C-1:0] sqx2_q, sqy2_q;
  logic [3*C-1:0] cubx, cuby;
  logic [4*C-1:0] quax, quay;
  logic [SUM_W-1:0] tx_d, ty_d, tx3_q, ty3_q, sum4_q;

  // Clamp the order: zero acts as one, five and up act as four.
  always_comb begin
    unique case (order_i) inside
      3'd0, 3'd1: order_dec = ORD_P1;
      3'd2:       order_dec = ORD_P2;
      3'd3:       order_dec = ORD_P3;
      default:    order_dec = ORD_P4;
    endcase
  end

  // Absolute differences of the sign-extended low coordinate bits.
  always_comb begin
    diff_x = {first_x_i[C-1], first_x_i[C-1:0]} - {second_x_i[C-1], second_x_i[C-1:0]};
    diff_y = {first_y_i[C-1], first_y_i[C-1:0]} - {second_y_i[C-1], second_y_i[C-1:0]};
    neg_x  = (~diff_x) + 1'b1;
    neg_y  = (~diff_y) + 1'b1;
    mag_x  = diff_x[C] ? neg_x[C-1:0] : diff_x[C-1:0];
    mag_y  = diff_y[C] ? neg_y[C-1:0] : diff_y[C-1:0];
  end

  // Control (valid and order) of the four front-end stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl1_q <= '{valid: start_i, order: order_dec};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  // Cubes and fourth powers are formed from the registered squares.
  assign cubx = sqx2_q * {{C{1'b0}}, dx2_q};
  assign cuby = sqy2_q * {{C{1'b0}}, dy2_q};
  assign quax = sqx2_q * sqx2_q;
  assign quay = sqy2_q * sqy2_q;

  // Pick the power that matches the order.
  always_comb begin
    case (ctl2_q.order)
      ORD_P1: begin
        tx_d = SUM_W'(dx2_q);
        ty_d = SUM_W'(dy2_q);
      end
      ORD_P2: begin
        tx_d = SUM_W'(sqx2_q);
        ty_d = SUM_W'(sqy2_q);
      end
      ORD_P3: begin
        tx_d = SUM_W'(cubx);
        ty_d = SUM_W'(cuby);
      end
      default: begin
        tx_d = SUM_W'(quax);
        ty_d = SUM_W'(quay);
      end
    endcase
  end

  // Payload stages: magnitudes, squares, selected powers, sum.
  always_ff @(posedge clk_i) begin
    dx1_q  <= mag_x;
    dy1_q  <= mag_y;
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    sqx2_q <= dx1_q * dx1_q;
    sqy2_q <= dy1_q * dy1_q;
    tx3_q  <= tx_d;
    ty3_q  <= ty_d;
    sum4_q <= tx3_q + ty3_q;
  end

  assign ctl_o = ctl4_q;
  assign sum_o = sum4_q;

endmodule

// File: rtl/mdist_cell.sv
// One root cell: decides a single bit of the root and updates the root's powers.
// Depends on mdist_pkg.
module mdist_cell #(
  parameter int unsigned ROOT_W = 17,
  parameter int unsigned SUM_W  = 68,
  parameter int unsigned BIT    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mdist_pkg::ctl_t     ctl_i,
  input  logic [SUM_W-1:0]    sum_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [SUM_W-1:0]    sq_i,
  input  logic [SUM_W-1:0]    cube_i,
  input  logic [SUM_W-1:0]    quad_i,
  output mdist_pkg::ctl_t     ctl_o,
  output logic [SUM_W-1:0]    sum_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SUM_W-1:0]    sq_o,
  output logic [SUM_W-1:0]    cube_o,
  output logic [SUM_W-1:0]    quad_o
);
  import mdist_pkg::*;

  localparam logic [SUM_W-1:0]  ONE      = SUM_W'(1);
  localparam logic [ROOT_W-1:0] LOW_MASK = ROOT_W'((2 ** (BIT + 1)) - 1);

  logic [SUM_W-1:0] r1, c1, c2, c3, c4, csel;
  logic             take;

  ctl_t              ctl_q;
  logic [SUM_W-1:0]  sum_q, sq_q, cube_q, quad_q;
  logic [ROOT_W-1:0] root_q;

  // Binomial expansion of (r + 2^BIT)^k: only shifts and small constant factors.
  always_comb begin
    r1 = SUM_W'(root_i);
    c1 = r1 + (ONE << BIT);
    c2 = sq_i + (r1 << (BIT + 1)) + (ONE << (2 * BIT));
    c3 = cube_i + SUM_W'(3) * (sq_i << BIT) + SUM_W'(3) * (r1 << (2 * BIT))
       + (ONE << (3 * BIT));
    c4 = quad_i + SUM_W'(4) * (cube_i << BIT) + SUM_W'(6) * (sq_i << (2 * BIT))
       + SUM_W'(4) * (r1 << (3 * BIT)) + (ONE << (4 * BIT));
  end

  // Keep the bit when the candidate's power does not exceed the sum.
  always_comb begin
    case (ctl_i.order)
      ORD_P1:  csel = c1;
      ORD_P2:  csel = c2;
      ORD_P3:  csel = c3;
      default: csel = c4;
    endcase
    take = (csel <= sum_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_i;
    if (take) begin
      root_q <= root_i | (ROOT_W'(1) << BIT);
      sq_q   <= c2;
      cube_q <= c3;
      quad_q <= c4;
    end else begin
      root_q <= root_i;
      sq_q   <= sq_i;
      cube_q <= cube_i;
      quad_q <= quad_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign sum_o  = sum_q;
  assign root_o = root_q;
  assign sq_o   = sq_q;
  assign cube_o = cube_q;
  assign quad_o = quad_q;

`ifndef ASSERT_OFF
  // Bits at and below this cell's position are still clear on entry.
  a_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |-> ((root_i & LOW_MASK) == '0))
    else $error("root bits below the cell position are already set");

  // For orders one and two, the root held here never has a power above the sum.
  a_under_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.valid && ctl_q.order == ORD_P1) |-> (SUM_W'(root_q) <= sum_q))
    else $error("first-order root exceeds the sum");

  a_sq_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.valid && ctl_q.order == ORD_P2) |-> (sq_q <= sum_q))
    else $error("second-order root power exceeds the sum");

  // A taken bit always appears in the registered root.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.valid && take) |=> root_q[BIT])
    else $error("accepted root bit was lost");
`endif

endmodule
